FILE: hw/rtl/ofdm_zero_forcing_equalizer_core_defines.svh
// ----------------------------------------------------------------------------
// OFDM equalizer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OFDM_ZERO_FORCING_EQUALIZER_CORE_DEFINES_SVH
`define OFDM_ZERO_FORCING_EQUALIZER_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define OZF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define OZF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ofdmzf_pkg.sv
// ----------------------------------------------------------------------------
// OFDM equalizer package
// Shared constants, word type and pilot helpers.
// ----------------------------------------------------------------------------
package ofdmzf_pkg;

    localparam int OFDMZF_FFT_POINTS = 64;
    localparam int OFDMZF_BIN_W      = 6;
    localparam int OFDMZF_PAIR_W     = 5;
    localparam int OFDMZF_PAIRS      = 32;
    localparam int OFDMZF_QDEPTH     = 4;
    localparam int OFDMZF_QBITS      = 17;
    localparam int OFDMZF_REM_W      = 50;

    localparam logic [OFDMZF_BIN_W-1:0] OFDMZF_FIRST_PILOT = 6'd7;
    localparam logic [OFDMZF_BIN_W-1:0] OFDMZF_LAST_PILOT  = 6'd57;
    localparam logic signed [15:0]      OFDMZF_INV_SQRT2   = 16'sd23170;
    // bit n set: pilot n (bin 7+2n) is -sqrt2
    localparam logic [31:0]             OFDMZF_PILOT_NEG   = 32'h0445_EBA;

    // word handed from front to back: sample and its bin estimate
    typedef struct packed {
        logic signed [15:0] xr;
        logic signed [15:0] xi;
        logic signed [15:0] hr;
        logic signed [15:0] hi;
    } ofdmzf_item_t;

    function automatic logic is_pilot(input logic [OFDMZF_BIN_W-1:0] bin);
        return (bin >= OFDMZF_FIRST_PILOT) && (bin <= OFDMZF_LAST_PILOT) && bin[0];
    endfunction

    function automatic logic pilot_neg(input logic [OFDMZF_BIN_W-1:0] bin);
        logic [OFDMZF_BIN_W-1:0] d;
        d = bin - OFDMZF_FIRST_PILOT;
        return OFDMZF_PILOT_NEG[d[OFDMZF_BIN_W-1:1]];
    endfunction

    // floor((x * p * 23170 + 2^14) / 2^15)
    function automatic logic signed [15:0] est_scale(input logic signed [15:0] x,
                                                     input logic neg);
        logic signed [31:0] p;
        logic signed [32:0] s;
        logic signed [32:0] t;
        p = x * OFDMZF_INV_SQRT2;
        s = neg ? -33'(p) : 33'(p);
        t = s + 33'sd16384;
        return t[30:15];
    endfunction

endpackage

FILE: hw/rtl/ofdm_zero_forcing_equalizer_core.sv
// ----------------------------------------------------------------------------
// OFDM zero-forcing equalizer core
// Per-bin channel estimate from pilots, complex divide of data samples.
// ----------------------------------------------------------------------------
// Throughput: one word per clock on both sides while the output is not stalled;
//   the divider is fully pipelined. Path: front register, queue, 4 arithmetic
//   stages, 18 divider stages, clamp.
// Training words update the estimate store and produce no output word.
// Reset (rst_n low, async): all estimates read as zero, pipeline and queue empty.
// ----------------------------------------------------------------------------
module ofdm_zero_forcing_equalizer_core
    import ofdmzf_pkg::*;
#(
    parameter int FIFO_DEPTH = OFDMZF_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] sample_re, [31:16] sample_im,
                                   // [37:32] subcarrier, [39:38] zero
    input  logic        s_tuser,   // [0] training
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] eq_re, [31:16] eq_im
    output logic [1:0]  m_tuser    // [0] no_estimate, [1] saturated
);

    // front -> queue
    logic         f_valid;
    logic         f_ready;
    ofdmzf_item_t f_item;
    // queue -> back
    logic         b_valid;
    logic         b_ready;
    ofdmzf_item_t b_item;

    // Front: pilot scaling by +-1/sqrt2 writes the bin-pair store; data words
    // read it (registered) and pass sample plus estimate on.
    ofdmzf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    // Queue lets the front keep taking words while the back is held.
    ofdmzf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_item  (b_item)
    );

    // Back: x * conj(h) / |h|^2 rounded half away from zero, clamped.
    ofdmzf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_item  (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: hw/rtl/ofdmzf_front.sv
// ----------------------------------------------------------------------------
// OFDM equalizer front end
// Accepts samples, updates the estimate store on pilots, looks up data bins.
// ----------------------------------------------------------------------------
module ofdmzf_front
    import ofdmzf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // sample_re, sample_im, subcarrier, pad
    input  logic         s_tuser,   // training
    output logic         q_valid,
    input  logic         q_ready,
    output ofdmzf_item_t q_item
);

    logic                     accept;
    logic                     train;
    logic                     wr_est;
    logic [OFDMZF_BIN_W-1:0]  bin;
    logic [OFDMZF_BIN_W:0]    bin_p1;
    logic [OFDMZF_PAIR_W-1:0] pair;
    logic signed [15:0]       xr;
    logic signed [15:0]       xi;
    logic signed [15:0]       er;
    logic signed [15:0]       ei;
    logic                     neg;

    // one entry per odd/even bin pair
    logic [31:0]              est_mem [OFDMZF_PAIRS];
    logic [OFDMZF_PAIRS-1:0]  est_vld_reg;

    logic                     f_valid_reg;
    logic                     f_valid_next;
    logic signed [15:0]       xr_reg;
    logic signed [15:0]       xi_reg;
    logic [31:0]              rd_reg;
    logic                     hv_reg;

    assign xr     = s_tdata[15:0];
    assign xi     = s_tdata[31:16];
    assign bin    = s_tdata[37:32];
    assign train  = s_tuser;
    assign bin_p1 = {1'b0, bin} + 7'd1;
    assign pair   = bin_p1[OFDMZF_PAIR_W:1];

    assign s_tready = !f_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign wr_est   = accept && train && is_pilot(bin);
    assign neg      = pilot_neg(bin);
    assign er       = est_scale(xr, neg);
    assign ei       = est_scale(xi, neg);

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept && !train)
        begin
            f_valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            est_vld_reg <= '0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            if (wr_est)
            begin
                est_vld_reg[pair] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_est)
        begin
            est_mem[pair] <= {er, ei};
        end
        if (accept && !train)
        begin
            rd_reg <= est_mem[pair];
            hv_reg <= est_vld_reg[pair];
            xr_reg <= xr;
            xi_reg <= xi;
        end
    end

    assign q_valid   = f_valid_reg;
    assign q_item.xr = xr_reg;
    assign q_item.xi = xi_reg;
    assign q_item.hr = hv_reg ? rd_reg[31:16] : 16'sd0;
    assign q_item.hi = hv_reg ? rd_reg[15:0]  : 16'sd0;

endmodule

FILE: hw/rtl/ofdmzf_fifo.sv
// ----------------------------------------------------------------------------
// OFDM equalizer word queue
// Small FIFO that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
module ofdmzf_fifo
    import ofdmzf_pkg::*;
#(
    parameter int DEPTH = OFDMZF_QDEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  ofdmzf_item_t wr_item,
    output logic         rd_valid,
    input  logic         rd_ready,
    output ofdmzf_item_t rd_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ofdmzf_item_t  buf_mem [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] rp_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          push;
    logic          pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = buf_mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wp_reg] <= wr_item;
        end
    end

endmodule

FILE: hw/rtl/ofdmzf_back.sv
// ----------------------------------------------------------------------------
// OFDM equalizer back end
// Complex zero-forcing divide: multiply, sum, pipelined restoring divide, clamp.
// ----------------------------------------------------------------------------
module ofdmzf_back
    import ofdmzf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ofdmzf_item_t in_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // eq_re, eq_im
    output logic [1:0]   m_tuser    // no_estimate, saturated
);

    localparam int QB = OFDMZF_QBITS;
    localparam int RW = OFDMZF_REM_W;

    typedef struct packed {
        logic          nest;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [QB-1:0] q_re;
        logic [QB-1:0] q_im;
        logic [32:0]   d;
    } div_t;

    logic en;

    // stage 0: popped word
    logic               b0_valid_reg;
    ofdmzf_item_t       b0_item_reg;
    // stage 1: products
    logic               b1_valid_reg;
    logic               b1_nest_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_hr_reg, p_hi_reg;
    // stage 2: numerators and denominator
    logic               b2_valid_reg;
    logic               b2_nest_reg;
    logic signed [32:0] nr_reg, ni_reg;
    logic [31:0]        den_reg;
    // stage 3: division operands
    logic               b3_valid_reg;
    logic               b3_nest_reg;
    logic               b3_neg_re_reg, b3_neg_im_reg;
    logic [RW-1:0]      b3_n_re_reg, b3_n_im_reg;
    logic [32:0]        b3_d_reg;
    logic [32:0]        mag_re, mag_im;

    div_t               dv_reg [QB+1];
    logic               dv_valid_reg [QB+1];

    logic               out_valid_reg;
    logic [15:0]        out_re_reg, out_im_reg;
    logic               out_nest_reg, out_sat_reg;
    logic [15:0]        c_re, c_im;
    logic               c_sat_re, c_sat_im;

    assign en       = !out_valid_reg || m_tready;
    assign in_ready = en;

    assign mag_re = nr_reg[32] ? -nr_reg : nr_reg;
    assign mag_im = ni_reg[32] ? -ni_reg : ni_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg  <= in_valid;
            b1_valid_reg  <= b0_valid_reg;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= dv_valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_item_reg <= in_item;

            b1_nest_reg <= (b0_item_reg.hr == 16'sd0) && (b0_item_reg.hi == 16'sd0);
            p_rr_reg    <= b0_item_reg.xr * b0_item_reg.hr;
            p_ii_reg    <= b0_item_reg.xi * b0_item_reg.hi;
            p_ir_reg    <= b0_item_reg.xi * b0_item_reg.hr;
            p_ri_reg    <= b0_item_reg.xr * b0_item_reg.hi;
            p_hr_reg    <= b0_item_reg.hr * b0_item_reg.hr;
            p_hi_reg    <= b0_item_reg.hi * b0_item_reg.hi;

            b2_nest_reg <= b1_nest_reg;
            nr_reg      <= 33'(p_rr_reg) + 33'(p_ii_reg);
            ni_reg      <= 33'(p_ir_reg) - 33'(p_ri_reg);
            den_reg     <= p_hr_reg[31:0] + p_hi_reg[31:0];

            // N = |num| * 2^14 + den, D = 2 * den
            b3_nest_reg   <= b2_nest_reg;
            b3_neg_re_reg <= nr_reg[32];
            b3_neg_im_reg <= ni_reg[32];
            b3_n_re_reg   <= {RW'(mag_re[31:0]) << 14} + RW'(den_reg);
            b3_n_im_reg   <= {RW'(mag_im[31:0]) << 14} + RW'(den_reg);
            b3_d_reg      <= {den_reg, 1'b0};
        end
    end

    // first divider stage: quotient beyond QB bits means overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].nest   <= b3_nest_reg;
            dv_reg[0].neg_re <= b3_neg_re_reg;
            dv_reg[0].neg_im <= b3_neg_im_reg;
            dv_reg[0].ovf_re <= b3_n_re_reg >= (RW'(b3_d_reg) << QB);
            dv_reg[0].ovf_im <= b3_n_im_reg >= (RW'(b3_d_reg) << QB);
            dv_reg[0].rem_re <= b3_n_re_reg;
            dv_reg[0].rem_im <= b3_n_im_reg;
            dv_reg[0].q_re   <= '0;
            dv_reg[0].q_im   <= '0;
            dv_reg[0].d      <= b3_d_reg;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        localparam int BIT = QB - k;
        logic [RW-1:0] dsh;
        logic          ge_re, ge_im;

        assign dsh   = RW'(dv_reg[k-1].d) << BIT;
        assign ge_re = dv_reg[k-1].rem_re >= dsh;
        assign ge_im = dv_reg[k-1].rem_im >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k].nest   <= dv_reg[k-1].nest;
                dv_reg[k].neg_re <= dv_reg[k-1].neg_re;
                dv_reg[k].neg_im <= dv_reg[k-1].neg_im;
                dv_reg[k].ovf_re <= dv_reg[k-1].ovf_re;
                dv_reg[k].ovf_im <= dv_reg[k-1].ovf_im;
                dv_reg[k].d      <= dv_reg[k-1].d;
                dv_reg[k].rem_re <= ge_re ? dv_reg[k-1].rem_re - dsh : dv_reg[k-1].rem_re;
                dv_reg[k].rem_im <= ge_im ? dv_reg[k-1].rem_im - dsh : dv_reg[k-1].rem_im;
                dv_reg[k].q_re   <= dv_reg[k-1].q_re | (QB'(ge_re) << BIT);
                dv_reg[k].q_im   <= dv_reg[k-1].q_im | (QB'(ge_im) << BIT);
            end
        end
    end

    // clamp to Q2.13: +32767 or -32768
    always_comb
    begin
        c_sat_re = dv_reg[QB].ovf_re || (dv_reg[QB].neg_re ?
                   (dv_reg[QB].q_re > QB'(32768)) : dv_reg[QB].q_re[QB-1:15] != '0);
        c_sat_im = dv_reg[QB].ovf_im || (dv_reg[QB].neg_im ?
                   (dv_reg[QB].q_im > QB'(32768)) : dv_reg[QB].q_im[QB-1:15] != '0);
        if (c_sat_re)
        begin
            c_re = dv_reg[QB].neg_re ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            c_re = dv_reg[QB].neg_re ? 16'(-dv_reg[QB].q_re) : dv_reg[QB].q_re[15:0];
        end
        if (c_sat_im)
        begin
            c_im = dv_reg[QB].neg_im ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            c_im = dv_reg[QB].neg_im ? 16'(-dv_reg[QB].q_im) : dv_reg[QB].q_im[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_nest_reg <= dv_reg[QB].nest;
            out_sat_reg  <= !dv_reg[QB].nest && (c_sat_re || c_sat_im);
            out_re_reg   <= dv_reg[QB].nest ? 16'd0 : c_re;
            out_im_reg   <= dv_reg[QB].nest ? 16'd0 : c_im;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tuser  = {out_sat_reg, out_nest_reg};

endmodule

FILE: hw/rtl/ofdmzf_checker.sv
// ----------------------------------------------------------------------------
// OFDM equalizer port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "ofdm_zero_forcing_equalizer_core_defines.svh"

module ofdmzf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser
);

    logic in_word;
    assign in_word = s_tvalid && s_tready;

    `OZF_ASSERT_NOW(a_in_known, in_word, !$isunknown({s_tdata, s_tuser}), "input word has unknown bits")
    `OZF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output word dropped")
    `OZF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
    `OZF_ASSERT_NOW(a_nest_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0 && !m_tuser[1], "no-estimate word not zero")
    `OZF_ASSERT_NOW(a_sat_limit, m_tvalid && m_tuser[1], m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000 || m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8000, "saturated word not at a limit")

endmodule

bind ofdm_zero_forcing_equalizer_core ofdmzf_checker u_ofdmzf_checker (.*);
